/* sv/cfdf_pkg.sv */
// Shared types and constants for the chunked file deframer.
// Holds parse phases, result codes, the result record and register map.
// No dependencies.
package cfdf_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 31;
  localparam int CODE_W = 3;

  // Header words, first byte in bits 7:0
  localparam logic [WORD_W-1:0] MAGIC_WORD      = 32'h4548_5045;  // "EPHE"
  localparam logic [WORD_W-1:0] JSON_WORD       = 32'h4E4F_534A;  // "JSON"
  localparam logic [WORD_W-1:0] DEFAULT_VERSION = 32'd2;

  // Bytes that must still follow before a field starts
  localparam int FIELD_BYTES     = 4;
  localparam int CHUNK_HDR_BYTES = 8;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_TYPE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_ERROR
  } phase_t;

  // Byte roles
  localparam logic [CODE_W-1:0] KIND_FILE_HDR  = 3'd0;
  localparam logic [CODE_W-1:0] KIND_CHUNK_HDR = 3'd1;
  localparam logic [CODE_W-1:0] KIND_PAYLOAD   = 3'd2;
  localparam logic [CODE_W-1:0] KIND_JSON      = 3'd3;
  localparam logic [CODE_W-1:0] KIND_TRAILER   = 3'd4;
  localparam logic [CODE_W-1:0] KIND_REJECTED  = 3'd5;

  // Error codes
  localparam logic [CODE_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [CODE_W-1:0] ERR_MAGIC       = 3'd1;
  localparam logic [CODE_W-1:0] ERR_VERSION     = 3'd2;
  localparam logic [CODE_W-1:0] ERR_NEG_LENGTH  = 3'd3;
  localparam logic [CODE_W-1:0] ERR_SECOND_JSON = 3'd4;
  localparam logic [CODE_W-1:0] ERR_TRUNCATED   = 3'd5;

  // Register map: one 32-bit register every 4 bytes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_SEL_LSB = 2;
  localparam logic REG_FILE_LENGTH      = 1'b0;
  localparam logic REG_EXPECTED_VERSION = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic [BYTE_W-1:0] byte_value;
    logic [WORD_W-1:0] chunk_tag;
    logic [LEN_W-1:0]  chunk_size;
    logic [LEN_W-1:0]  payload_position;
    logic              chunk_announced;
    logic              last_of_chunk;
    logic              file_done;
    logic [CODE_W-1:0] error_code;
  } result_t;

endpackage

/* sv/cfdf_cfg_regs.sv */
// Configuration register file of the deframer: file length and expected version.
// APB-style write and read, pready tied high. Depends on cfdf_pkg.
module cfdf_cfg_regs import cfdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LEN_W-1:0]      file_length,
  output logic [WORD_W-1:0]     expected_version
);

  logic reg_sel;
  logic wr_en;

  assign reg_sel = paddr[REG_SEL_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the selected register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length      <= '0;
      expected_version <= DEFAULT_VERSION;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FILE_LENGTH:      file_length      <= pwdata[LEN_W-1:0];
        REG_EXPECTED_VERSION: expected_version <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_FILE_LENGTH:      prdata = {1'b0, file_length};
      REG_EXPECTED_VERSION: prdata = expected_version;
      default:              prdata = '0;
    endcase
  end

endmodule

/* sv/cfdf_parser.sv */
// Parse state machine of the deframer: classifies one file byte per step.
// Holds phase, field and payload counters, chunk tag and size, error latch.
// Depends on cfdf_pkg.
module cfdf_parser import cfdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] file_byte,
  input  logic [LEN_W-1:0]  file_length,
  input  logic [WORD_W-1:0] expected_version,
  output result_t           result
);

  phase_t              phase, phase_next;
  logic [1:0]          field_count, field_count_next;
  logic [WORD_W-1:0]   shift_word, shift_word_next;
  logic [WORD_W-1:0]   current_tag, current_tag_next;
  logic [LEN_W-1:0]    current_size, current_size_next;
  logic [LEN_W-1:0]    payload_count, payload_count_next;
  logic [LEN_W-1:0]    bytes_left, bytes_left_next;
  logic                json_seen, json_seen_next;
  logic [CODE_W-1:0]   latched_error, latched_error_next;

  phase_t              cur_phase;
  logic [1:0]          cur_count;
  logic                restart;
  logic                start;
  logic                empty_file;
  logic [LEN_W-1:0]    incl;
  logic [LEN_W-1:0]    rem;
  logic                rem_zero;
  logic [WORD_W-1:0]   word;
  logic                first_byte;
  logic                last_byte;
  logic                tag_is_json;
  logic [LEN_W-1:0]    count_inc;
  logic                payload_end;
  logic [CODE_W-1:0]   step_err;
  logic [CODE_W-1:0]   step_kind;
  logic                clean;
  logic                length_ok;
  logic                in_error;
  logic                fail;

  // Decode the byte against the current phase
  always_comb begin
    restart     = (phase != PH_MAGIC) && (bytes_left == '0);
    cur_phase   = restart ? PH_MAGIC : phase;
    cur_count   = restart ? 2'd0 : field_count;
    start       = (cur_phase == PH_MAGIC) && (cur_count == 2'd0);
    incl        = start ? file_length : bytes_left;
    empty_file  = start && (incl == '0);
    rem         = incl - LEN_W'(1);
    rem_zero    = (rem == '0);
    word        = {file_byte, shift_word[WORD_W-1:BYTE_W]};
    first_byte  = (cur_count == 2'd0);
    last_byte   = (cur_count == 2'd3);
    tag_is_json = (current_tag == JSON_WORD);
    count_inc   = payload_count + LEN_W'(1);
    payload_end = (count_inc >= current_size);
    step_err    = ERR_NONE;
    step_kind   = KIND_FILE_HDR;
    clean       = 1'b0;
    length_ok   = 1'b0;
    case (cur_phase)
      PH_MAGIC: begin
        if (first_byte && (incl < LEN_W'(FIELD_BYTES))) begin
          step_err = ERR_TRUNCATED;
        end else if (last_byte && (word != MAGIC_WORD)) begin
          step_err = ERR_MAGIC;
        end
      end
      PH_VERSION: begin
        if (first_byte && (incl < LEN_W'(FIELD_BYTES))) begin
          step_err = ERR_TRUNCATED;
        end else if (last_byte) begin
          if (word != expected_version) step_err = ERR_VERSION;
          else clean = rem_zero;
        end
      end
      PH_TYPE: begin
        step_kind = KIND_CHUNK_HDR;
        if (first_byte && (incl < LEN_W'(CHUNK_HDR_BYTES))) step_err = ERR_TRUNCATED;
      end
      PH_LENGTH: begin
        step_kind = KIND_CHUNK_HDR;
        if (last_byte) begin
          if (word[WORD_W-1]) step_err = ERR_NEG_LENGTH;
          else if (rem < word[LEN_W-1:0]) step_err = ERR_TRUNCATED;
          else if (tag_is_json && json_seen) step_err = ERR_SECOND_JSON;
          else length_ok = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        step_kind = tag_is_json ? KIND_JSON : KIND_PAYLOAD;
      end
      PH_TRAILER: begin
        step_kind = KIND_TRAILER;
        if (first_byte && (incl < LEN_W'(FIELD_BYTES))) step_err = ERR_TRUNCATED;
        else if (last_byte) clean = rem_zero;
      end
      default: begin
        step_kind = KIND_REJECTED;
        step_err  = latched_error;
      end
    endcase
    in_error = (cur_phase == PH_ERROR);
    fail     = (step_err != ERR_NONE) && !in_error;
  end

  // Next phase and field counter
  always_comb begin
    phase_next       = cur_phase;
    field_count_next = cur_count;
    if (empty_file) begin
      phase_next       = PH_MAGIC;
      field_count_next = 2'd0;
    end else if (in_error || fail) begin
      phase_next       = rem_zero ? PH_MAGIC : PH_ERROR;
      field_count_next = 2'd0;
    end else if (rem_zero) begin
      phase_next       = PH_MAGIC;
      field_count_next = 2'd0;
    end else begin
      field_count_next = (cur_phase == PH_PAYLOAD) ? 2'd0 : cur_count + 2'd1;
      case (cur_phase)
        PH_MAGIC:   if (last_byte) phase_next = PH_VERSION;
        PH_VERSION: if (last_byte) phase_next = PH_TYPE;
        PH_TYPE:    if (last_byte) phase_next = PH_LENGTH;
        PH_LENGTH: begin
          if (last_byte) phase_next = (word != '0) ? PH_PAYLOAD : PH_TRAILER;
        end
        PH_PAYLOAD: if (payload_end) phase_next = PH_TRAILER;
        PH_TRAILER: if (last_byte) phase_next = PH_TYPE;
        default:    phase_next = cur_phase;
      endcase
    end
  end

  // Chunk bookkeeping and the result record
  always_comb begin
    shift_word_next    = shift_word;
    current_tag_next   = current_tag;
    current_size_next  = current_size;
    payload_count_next = payload_count;
    json_seen_next     = json_seen;
    latched_error_next = latched_error;
    bytes_left_next    = empty_file ? '0 : rem;
    result             = '0;
    result.byte_value  = file_byte;
    if (start) begin
      current_tag_next   = '0;
      current_size_next  = '0;
      json_seen_next     = 1'b0;
      latched_error_next = ERR_NONE;
    end
    if (empty_file) begin
      result.kind       = KIND_REJECTED;
      result.error_code = ERR_TRUNCATED;
    end else if (in_error) begin
      result.kind       = KIND_REJECTED;
      result.error_code = latched_error;
    end else if (fail) begin
      result.kind        = KIND_REJECTED;
      result.error_code  = step_err;
      latched_error_next = step_err;
    end else begin
      shift_word_next = word;
      case (cur_phase)
        PH_TYPE: begin
          if (first_byte) begin
            current_tag_next  = '0;
            current_size_next = '0;
          end else if (last_byte) begin
            current_tag_next = word;
          end
        end
        PH_LENGTH: begin
          if (length_ok) begin
            current_size_next  = word[LEN_W-1:0];
            payload_count_next = '0;
            if (tag_is_json) json_seen_next = 1'b1;
          end
        end
        PH_PAYLOAD: payload_count_next = count_inc;
        default: ;
      endcase
      result.kind            = step_kind;
      result.chunk_tag       = current_tag_next;
      result.chunk_size      = current_size_next;
      result.payload_position = (cur_phase == PH_PAYLOAD) ? payload_count : '0;
      result.chunk_announced = length_ok;
      result.last_of_chunk   = (cur_phase == PH_PAYLOAD) && payload_end;
      // File ran out: clean finish or truncation
      if (rem_zero) begin
        if (clean) begin
          result.file_done = 1'b1;
        end else begin
          result.error_code  = ERR_TRUNCATED;
          latched_error_next = ERR_TRUNCATED;
        end
      end
    end
  end

  // Advance parse state on each stepped byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      field_count   <= 2'd0;
      current_tag   <= '0;
      current_size  <= '0;
      payload_count <= '0;
      bytes_left    <= '0;
      json_seen     <= 1'b0;
      latched_error <= ERR_NONE;
    end else if (step) begin
      phase         <= phase_next;
      field_count   <= field_count_next;
      current_tag   <= current_tag_next;
      current_size  <= current_size_next;
      payload_count <= payload_count_next;
      bytes_left    <= bytes_left_next;
      json_seen     <= json_seen_next;
      latched_error <= latched_error_next;
    end
  end

  // Byte shifter for multi-byte fields
  always_ff @(posedge clk) begin
    if (step) begin
      shift_word <= shift_word_next;
    end
  end

  a_count_zero_outside_fields: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_ERROR) |-> field_count == 2'd0)
    else $error("field counter left nonzero outside a header field");

  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |-> latched_error != ERR_NONE)
    else $error("error phase without a latched error code");

  a_bytes_left_in_file: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_MAGIC) |-> bytes_left != '0)
    else $error("parse phase active with no file bytes left");

  a_done_is_clean: assert property (@(posedge clk) disable iff (rst)
    (step && result.file_done) |->
      (result.error_code == ERR_NONE && result.kind == KIND_TRAILER) ||
      (result.error_code == ERR_NONE && result.kind == KIND_FILE_HDR))
    else $error("file done flagged on a byte that is not a clean last field byte");

endmodule

/* sv/chunk_file_deframer_unit.sv */
// Chunked file deframer, top level.
// A byte moves from the input register through the parser into the result register.
// Throughput: one byte per cycle while result_stall is low; the registers decouple both sides.
// Reset (rst, synchronous) empties both registers, clears the parse state and loads defaults.
// No memory, so no clearing pass: bytes are taken right after reset.
module chunk_file_deframer_unit import cfdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // byte channel
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [BYTE_W-1:0]     file_byte,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [CODE_W-1:0]     kind,
  output logic [BYTE_W-1:0]     byte_value,
  output logic [WORD_W-1:0]     chunk_tag,
  output logic [LEN_W-1:0]      chunk_size,
  output logic [LEN_W-1:0]      payload_position,
  output logic                  chunk_announced,
  output logic                  last_of_chunk,
  output logic                  file_done,
  output logic [CODE_W-1:0]     error_code,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LEN_W-1:0]  file_length;
  logic [WORD_W-1:0] expected_version;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  result_t           step_result;
  result_t           result_reg;

  cfdf_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .file_length      (file_length),
    .expected_version (expected_version)
  );

  cfdf_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .file_byte        (in_byte),
    .file_length      (file_length),
    .expected_version (expected_version),
    .result           (step_result)
  );

  // Move the held byte into the result register when that slot frees up
  assign advance    = in_valid && (!result_valid || !result_stall);
  assign byte_stall = in_valid && result_valid && result_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= file_byte;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= step_result;
    end
  end

  assign kind             = result_reg.kind;
  assign byte_value       = result_reg.byte_value;
  assign chunk_tag        = result_reg.chunk_tag;
  assign chunk_size       = result_reg.chunk_size;
  assign payload_position = result_reg.payload_position;
  assign chunk_announced  = result_reg.chunk_announced;
  assign last_of_chunk    = result_reg.last_of_chunk;
  assign file_done        = result_reg.file_done;
  assign error_code       = result_reg.error_code;

endmodule

/* bench/tb_top.sv */
// Testbench for chunk_file_deframer_unit: streams chunked files byte by byte and checks
// every per-byte report against a scripted report or a cycle-free deframer model in this file.
// Depends on cfdf_pkg (widths, phase enum, kind and error codes, register map).
module tb_top;
  import cfdf_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int ITEM_TARGET = 1350;
  localparam int HOLD_CYCLES = 400;
  localparam int N_SCRIPT    = 32;

  typedef enum logic [1:0] {STEP_BYTE, STEP_SET_LEN, STEP_SET_VER} step_op_t;

  typedef struct packed {
    step_op_t          op;
    logic [31:0]       value;
    logic              typed;
    logic [CODE_W-1:0] kind;
    logic              done;
    logic [CODE_W-1:0] err;
  } script_step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  logic [BYTE_W-1:0]     file_byte = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [CODE_W-1:0]     kind;
  logic [BYTE_W-1:0]     byte_value;
  logic [WORD_W-1:0]     chunk_tag;
  logic [LEN_W-1:0]      chunk_size;
  logic [LEN_W-1:0]      payload_position;
  logic                  chunk_announced;
  logic                  last_of_chunk;
  logic                  file_done;
  logic [CODE_W-1:0]     error_code;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  chunk_file_deframer_unit dut (.*);

  always #5 clk = ~clk;

  // Register copies and deframer state as the model sees them
  logic [LEN_W-1:0]  cur_file_len = '0;
  logic [WORD_W-1:0] cur_version = DEFAULT_VERSION;
  phase_t            dfr_phase = PH_MAGIC;
  logic [1:0]        dfr_field_cnt = '0;
  logic [WORD_W-1:0] dfr_word = '0;
  logic [WORD_W-1:0] dfr_tag = '0;
  logic [LEN_W-1:0]  dfr_size = '0;
  logic [LEN_W-1:0]  dfr_pay_idx = '0;
  logic [LEN_W-1:0]  dfr_left = '0;
  logic              dfr_json_seen = 1'b0;
  logic [CODE_W-1:0] dfr_err = ERR_NONE;

  result_t     byte_reports_due[$];
  logic [7:0]  file_img[$];
  result_t     seen_report;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          sender_steady = 1'b0;
  bit          hold_armed = 1'b0;
  int unsigned cycle_count = 0;

  // Opening script: reset state, short and bad magic, then a clean file with a
  // zero-length JSON chunk under the all-ones version word
  script_step_t opening_script [N_SCRIPT] = '{
    '{STEP_BYTE,    32'hFF, 1'b1, KIND_REJECTED, 1'b0, ERR_TRUNCATED},
    '{STEP_SET_LEN, 32'd3,  1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h45, 1'b1, KIND_REJECTED, 1'b0, ERR_TRUNCATED},
    '{STEP_BYTE,    32'h00, 1'b1, KIND_REJECTED, 1'b0, ERR_TRUNCATED},
    '{STEP_BYTE,    32'h80, 1'b1, KIND_REJECTED, 1'b0, ERR_TRUNCATED},
    '{STEP_SET_LEN, 32'd4,  1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h45, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h50, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h48, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h58, 1'b1, KIND_REJECTED, 1'b0, ERR_MAGIC},
    '{STEP_SET_VER, 32'hFFFF_FFFF, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_SET_LEN, 32'd20, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h45, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h50, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h48, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h45, 1'b1, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'hFF, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'hFF, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'hFF, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'hFF, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h4A, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h53, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h4F, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h4E, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h00, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h00, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h00, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h00, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h7F, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h80, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'h01, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE},
    '{STEP_BYTE,    32'hFE, 1'b0, KIND_FILE_HDR, 1'b0, ERR_NONE}
  };

  // Advance the deframer model by one byte and return its report
  function automatic result_t classify_byte(input logic [7:0] b);
    result_t           r;
    logic [LEN_W-1:0]  incl;
    logic [LEN_W-1:0]  rem;
    logic [WORD_W-1:0] word;
    logic [CODE_W-1:0] e;
    logic              clean;
    logic              last_field;
    logic              is_json;
    r = '0;
    r.byte_value = b;
    e = ERR_NONE;
    clean = 1'b0;
    if (dfr_phase != PH_MAGIC && dfr_left == 0) begin
      dfr_phase = PH_MAGIC;
      dfr_field_cnt = '0;
    end
    // Start of file: reload the byte budget and clear per-file state
    if (dfr_phase == PH_MAGIC && dfr_field_cnt == 0) begin
      dfr_left = cur_file_len;
      dfr_json_seen = 1'b0;
      dfr_err = ERR_NONE;
      dfr_tag = '0;
      dfr_size = '0;
      if (dfr_left == 0) begin
        r.kind = KIND_REJECTED;
        r.error_code = ERR_TRUNCATED;
        return r;
      end
    end
    incl = dfr_left;
    rem = incl - LEN_W'(1);
    dfr_left = rem;
    word = {b, dfr_word[WORD_W-1:8]};
    last_field = (dfr_field_cnt == 2'd3);

    case (dfr_phase)
      PH_MAGIC: begin
        if (dfr_field_cnt == 0 && incl < LEN_W'(FIELD_BYTES)) begin
          e = ERR_TRUNCATED;
        end else begin
          r.kind = KIND_FILE_HDR;
          if (last_field && word != MAGIC_WORD) e = ERR_MAGIC;
          else if (last_field) dfr_phase = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (dfr_field_cnt == 0 && incl < LEN_W'(FIELD_BYTES)) begin
          e = ERR_TRUNCATED;
        end else begin
          r.kind = KIND_FILE_HDR;
          if (last_field && word != cur_version) begin
            e = ERR_VERSION;
          end else if (last_field) begin
            dfr_phase = PH_TYPE;
            clean = (rem == 0);
          end
        end
      end
      PH_TYPE: begin
        if (dfr_field_cnt == 0 && incl < LEN_W'(CHUNK_HDR_BYTES)) begin
          e = ERR_TRUNCATED;
        end else begin
          if (dfr_field_cnt == 0) begin
            dfr_tag = '0;
            dfr_size = '0;
          end
          r.kind = KIND_CHUNK_HDR;
          if (last_field) begin
            dfr_tag = word;
            dfr_phase = PH_LENGTH;
          end
          r.chunk_tag = dfr_tag;
        end
      end
      PH_LENGTH: begin
        r.kind = KIND_CHUNK_HDR;
        r.chunk_tag = dfr_tag;
        if (last_field) begin
          is_json = (dfr_tag == JSON_WORD);
          if (word[31]) begin
            e = ERR_NEG_LENGTH;
          end else if ({1'b0, rem} < word) begin
            e = ERR_TRUNCATED;
          end else if (is_json && dfr_json_seen) begin
            e = ERR_SECOND_JSON;
          end else begin
            dfr_size = word[LEN_W-1:0];
            r.chunk_announced = 1'b1;
            if (is_json) dfr_json_seen = 1'b1;
            dfr_pay_idx = '0;
            dfr_phase = (word != 0) ? PH_PAYLOAD : PH_TRAILER;
          end
        end
        r.chunk_size = dfr_size;
      end
      PH_PAYLOAD: begin
        r.kind = (dfr_tag == JSON_WORD) ? KIND_JSON : KIND_PAYLOAD;
        r.chunk_tag = dfr_tag;
        r.chunk_size = dfr_size;
        r.payload_position = dfr_pay_idx;
        dfr_pay_idx = dfr_pay_idx + LEN_W'(1);
        if (dfr_pay_idx >= dfr_size) begin
          r.last_of_chunk = 1'b1;
          dfr_phase = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (dfr_field_cnt == 0 && incl < LEN_W'(FIELD_BYTES)) begin
          e = ERR_TRUNCATED;
        end else begin
          r.kind = KIND_TRAILER;
          r.chunk_tag = dfr_tag;
          r.chunk_size = dfr_size;
          if (last_field) begin
            dfr_phase = PH_TYPE;
            clean = (rem == 0);
          end
        end
      end
      default: begin
        r.kind = KIND_REJECTED;
        e = dfr_err;
        if (rem == 0) begin
          dfr_phase = PH_MAGIC;
          dfr_field_cnt = '0;
        end
      end
    endcase

    // Latch a new error, or advance the field counter and close the file
    if (dfr_phase != PH_ERROR || e == ERR_NONE || r.kind != KIND_REJECTED) begin
      if (e != ERR_NONE) begin
        r.kind = KIND_REJECTED;
        r.chunk_tag = '0;
        r.chunk_size = '0;
        r.payload_position = '0;
        r.chunk_announced = 1'b0;
        r.last_of_chunk = 1'b0;
        dfr_err = e;
        dfr_phase = (rem == 0) ? PH_MAGIC : PH_ERROR;
        dfr_field_cnt = '0;
      end else begin
        if (r.kind == KIND_PAYLOAD || r.kind == KIND_JSON || dfr_phase == PH_PAYLOAD)
          dfr_field_cnt = '0;
        else
          dfr_field_cnt = dfr_field_cnt + 2'd1;
        dfr_word = word;
        if (rem == 0) begin
          if (clean) begin
            r.file_done = 1'b1;
          end else begin
            e = ERR_TRUNCATED;
            dfr_err = ERR_TRUNCATED;
          end
          dfr_phase = PH_MAGIC;
          dfr_field_cnt = '0;
        end
      end
    end
    r.error_code = e;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_report(input result_t got, input result_t want);
    if (got.kind != want.kind) flag_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.byte_value != want.byte_value)
      flag_mismatch("byte_value", 32'(got.byte_value), 32'(want.byte_value));
    if (got.chunk_tag != want.chunk_tag)
      flag_mismatch("chunk_tag", got.chunk_tag, want.chunk_tag);
    if (got.chunk_size != want.chunk_size)
      flag_mismatch("chunk_size", 32'(got.chunk_size), 32'(want.chunk_size));
    if (got.payload_position != want.payload_position)
      flag_mismatch("payload_position", 32'(got.payload_position),
                    32'(want.payload_position));
    if (got.chunk_announced != want.chunk_announced)
      flag_mismatch("chunk_announced", 32'(got.chunk_announced),
                    32'(want.chunk_announced));
    if (got.last_of_chunk != want.last_of_chunk)
      flag_mismatch("last_of_chunk", 32'(got.last_of_chunk), 32'(want.last_of_chunk));
    if (got.file_done != want.file_done)
      flag_mismatch("file_done", 32'(got.file_done), 32'(want.file_done));
    if (got.error_code != want.error_code)
      flag_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
  endtask

  // Offer one byte in bursts with random gaps; record its report once accepted
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t typed_want);
    logic    taken;
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    file_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !byte_stall;
      @(posedge clk);
    end
    predicted = classify_byte(b);
    byte_reports_due.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // Hold the sender until every report of the accepted bytes is back
  task automatic drain_reports();
    byte_valid <= 1'b0;
    while (byte_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    logic ready_seen;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(reg_sel) << REG_SEL_LSB;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = pready;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_FILE_LENGTH) cur_file_len = value[LEN_W-1:0];
    else cur_version = value;
    @(posedge clk);
  endtask

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_img.push_back(w[8*i +: 8]);
  endfunction

  // Build a mostly well-formed file: header, a few chunks, rare corruption
  task automatic build_file();
    int          n_chunks;
    logic [31:0] tag;
    logic [31:0] len;
    int          plen;
    file_img.delete();
    put_word(($urandom_range(0, 15) == 0) ? $urandom() : MAGIC_WORD);
    put_word(($urandom_range(0, 11) == 0) ? $urandom() : cur_version);
    n_chunks = $urandom_range(0, 4);
    for (int c = 0; c < n_chunks; c++) begin
      tag = ($urandom_range(0, 9) < 3) ? JSON_WORD : $urandom();
      case ($urandom_range(0, 15))
        0:       len = $urandom() | 32'h8000_0000;
        1:       len = $urandom_range(41, 300);
        2, 3:    len = $urandom_range(13, 40);
        default: len = $urandom_range(0, 12);
      endcase
      put_word(tag);
      put_word(len);
      plen = (len > 40) ? $urandom_range(0, 12) : int'(len);
      for (int i = 0; i < plen; i++) file_img.push_back(8'($urandom()));
      put_word($urandom());
    end
    if ($urandom_range(0, 7) == 0)
      file_img[$urandom_range(0, file_img.size() - 1)] = 8'($urandom());
  endtask

  // Receiver stall pattern, plus one long hold-off so the block backs up
  initial begin
    int tick;
    bit hold_taken;
    tick = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((tick / 97) % 4)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 9) < 6);
          default: result_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest pending report
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen_report = {kind, byte_value, chunk_tag, chunk_size, payload_position,
                     chunk_announced, last_of_chunk, file_done, error_code};
      if (byte_reports_due.size() == 0)
        flag_mismatch("unexpected result, byte", 32'(seen_report.byte_value), '0);
      else
        check_report(seen_report, byte_reports_due.pop_front());
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    result_t     want;
    int          file_index;
    int          flen;
    int          trunc;
    int          copies;
    int          n_send;
    logic [31:0] ver;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the opening script
    for (int s = 0; s < N_SCRIPT; s++) begin
      case (opening_script[s].op)
        STEP_SET_LEN: begin
          drain_reports();
          write_reg(REG_FILE_LENGTH, opening_script[s].value);
        end
        STEP_SET_VER: begin
          drain_reports();
          write_reg(REG_EXPECTED_VERSION, opening_script[s].value);
        end
        default: begin
          want = '0;
          want.kind = opening_script[s].kind;
          want.byte_value = opening_script[s].value[7:0];
          want.file_done = opening_script[s].done;
          want.error_code = opening_script[s].err;
          send_byte(opening_script[s].value[7:0], opening_script[s].typed, want);
        end
      endcase
    end

    // Random files, one length setting per group of back-to-back files
    file_index = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_reports();
      if (file_index % 5 == 0) begin
        case ((file_index / 5) % 4)
          0:       ver = DEFAULT_VERSION;
          1:       ver = 32'h0;
          2:       ver = $urandom();
          default: ver = 32'hFFFF_FFFF;
        endcase
        write_reg(REG_EXPECTED_VERSION, ver);
      end
      if (!hold_armed && items_sent > 500) hold_armed = 1'b1;
      build_file();
      case ($urandom_range(0, 9))
        0: flen = 0;
        1, 2: begin
          trunc = $urandom_range(1, 9);
          flen = (file_img.size() > trunc) ? file_img.size() - trunc : 1;
        end
        3:       flen = file_img.size() + $urandom_range(1, 6);
        default: flen = file_img.size();
      endcase
      write_reg(REG_FILE_LENGTH, flen);
      sender_steady = ($urandom_range(0, 3) == 0);
      copies = $urandom_range(1, 2);
      for (int k = 0; k < copies; k++) begin
        if (k != 0) build_file();
        n_send = (flen == 0) ? $urandom_range(1, 3) : flen;
        for (int i = 0; i < n_send; i++)
          send_byte((i < file_img.size()) ? file_img[i] : 8'($urandom()), 1'b0, '0);
      end
      file_index++;
    end

    // Largest file length: the file never ends within the run
    drain_reports();
    write_reg(REG_FILE_LENGTH, 32'h7FFF_FFFF);
    build_file();
    for (int i = 0; i < file_img.size(); i++) send_byte(file_img[i], 1'b0, '0);

    drain_reports();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
